[sv/block_delta_mutation_encoder_top_assert.svh]
// ============================================================================
// block_delta_mutation_encoder_top_assert.svh
// Assertion macros shared by the checker of the delta mutation encoder.
// ============================================================================
`ifndef BLOCK_DELTA_MUTATION_ENCODER_TOP_ASSERT_SVH
`define BLOCK_DELTA_MUTATION_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, masked while reset is low.
`define BDME_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is low.
`define BDME_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define BDME_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/bdme_pkg.sv]
// ============================================================================
// bdme_pkg
// Types, constants and helpers shared by the delta mutation encoder.
// ============================================================================
package bdme_pkg;

    localparam int POSITION_BITS  = 32;
    localparam int COST_BITS      = 40;
    localparam int SUM_BITS       = ((POSITION_BITS > COST_BITS) ? POSITION_BITS : COST_BITS) + 2;
    localparam int QUEUE_DEPTH    = 4;  // power of two
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [15:0]          BLOCK_SIZE_RESET   = 16'd64;
    localparam logic [7:0]           HEADER_BYTES_RESET = 8'd17;
    localparam logic [COST_BITS-1:0] COST_MAX           = '1;
    localparam logic [16:0]          FULL_BLOCK         = 17'h10000;

    typedef logic [POSITION_BITS-1:0] t_pos;

    typedef enum logic [1:0] {
        KIND_UPDATE = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_INSERT = 2'd2,
        KIND_END    = 2'd3
    } t_kind;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_BLOCK_SIZE   = 1'b0,
        CFG_HEADER_BYTES = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_pos        cpos;
        logic [15:0] fill;
        logic        differs;
        t_pos        pend;
        logic        prev;
        t_pos        ocnt;
        t_pos        ncnt;
        logic        open;
    } t_fe_state;

    localparam t_fe_state FE_RESET = '{
        cpos: '0, fill: '0, differs: 1'b0, pend: '0, prev: 1'b0,
        ocnt: '0, ncnt: '0, open: 1'b1
    };

    typedef struct packed {
        logic valid;
        t_pos pos;
        t_pos len;
    } t_rec;

    typedef struct packed {
        t_fe_state st;
        t_rec      rec;
    } t_step;

    // Records caused by one input item: update, surplus, end.
    typedef struct packed {
        t_rec  upd;
        t_rec  sur;
        t_kind sur_kind;
        logic  eos;
    } t_bundle;

    typedef struct packed {
        logic    valid;
        t_bundle bundle;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [31:0] to_out32(input t_pos v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

endpackage

[sv/bdme_front.sv]
// ============================================================================
// bdme_front
// Accepts byte pairs, tracks blocks and runs, and queues record bundles.
// ============================================================================
module bdme_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_old_byte,
    input  logic [7:0]         i_new_byte,
    input  logic               i_old_present,
    input  logic               i_new_present,
    input  logic               i_last_item,
    input  logic [15:0]        i_block_size,
    input  bdme_pkg::t_q_stat  i_q_stat,
    output bdme_pkg::t_push    o_push
);
    import bdme_pkg::*;

    t_fe_state r_st;
    t_fe_state n_st;
    t_rec      upd;
    t_rec      sur;
    t_kind     sur_kind;
    logic      accept;

    // Close the current block of the given size.
    function automatic t_step close_block(input t_fe_state s, input t_pos size);
        t_step r;
        r.st  = s;
        r.rec = '0;
        if (s.differs) begin
            r.st.pend = s.pend + size;
            r.st.prev = 1'b1;
        end else if (s.prev) begin
            r.rec.valid = 1'b1;
            r.rec.pos   = s.cpos - size - s.pend;
            r.rec.len   = s.pend;
            r.st.pend   = '0;
            r.st.prev   = 1'b0;
        end
        r.st.fill    = '0;
        r.st.differs = 1'b0;
        return r;
    endfunction

    // End of overlap: close a partial block, emit any open run.
    function automatic t_step flush(input t_fe_state s);
        t_step r;
        r.st  = s;
        r.rec = '0;
        if (s.fill != '0) begin
            r = close_block(s, POSITION_BITS'(s.fill));
        end
        if (r.st.prev) begin
            r.rec.valid = 1'b1;
            r.rec.pos   = r.st.cpos - r.st.pend;
            r.rec.len   = r.st.pend;
            r.st.pend   = '0;
            r.st.prev   = 1'b0;
        end
        return r;
    endfunction

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        t_fe_state   s;
        t_step       c;
        logic [16:0] filled;
        logic [16:0] target;
        s        = r_st;
        c        = '0;
        upd      = '0;
        sur      = '0;
        sur_kind = KIND_UPDATE;
        filled   = {1'b0, r_st.fill} + 17'd1;
        target   = (i_block_size == '0) ? FULL_BLOCK : {1'b0, i_block_size};

        if (s.open && i_old_present && i_new_present) begin
            s.cpos = s.cpos + 1'b1;
            if (i_old_byte != i_new_byte) begin
                s.differs = 1'b1;
            end
            if (filled >= target) begin
                c   = close_block(s, POSITION_BITS'(filled));
                s   = c.st;
                upd = c.rec;
            end else begin
                s.fill = filled[15:0];
            end
        end else if (s.open && (i_old_present || i_new_present)) begin
            c      = flush(s);
            s      = c.st;
            upd    = c.rec;
            s.open = 1'b0;
        end

        if (i_old_present) begin
            s.ocnt = s.ocnt + 1'b1;
        end
        if (i_new_present) begin
            s.ncnt = s.ncnt + 1'b1;
        end

        if (i_last_item) begin
            if (s.open) begin
                c = flush(s);
                s = c.st;
                if (c.rec.valid) begin
                    upd = c.rec;
                end
            end
            if (s.ocnt > s.ncnt) begin
                sur.valid = 1'b1;
                sur.pos   = s.ncnt;
                sur.len   = s.ocnt - s.ncnt;
                sur_kind  = KIND_DELETE;
            end else if (s.ncnt > s.ocnt) begin
                sur.valid = 1'b1;
                sur.pos   = s.ocnt;
                sur.len   = s.ncnt - s.ocnt;
                sur_kind  = KIND_INSERT;
            end
            s = FE_RESET;
        end
        n_st = s;
    end

    always_comb begin
        o_push.valid           = accept && (upd.valid || i_last_item);
        o_push.bundle.upd      = upd;
        o_push.bundle.sur      = sur;
        o_push.bundle.sur_kind = sur_kind;
        o_push.bundle.eos      = i_last_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= FE_RESET;
        end else if (accept) begin
            r_st <= n_st;
        end
    end

endmodule

[sv/bdme_queue.sv]
// ============================================================================
// bdme_queue
// Short FIFO of record bundles between front and back.
// ============================================================================
module bdme_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bdme_pkg::t_push   i_push,
    input  logic              i_pop,
    output bdme_pkg::t_bundle o_head,
    output bdme_pkg::t_q_stat o_stat
);
    import bdme_pkg::*;

    t_bundle              r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr;
    logic [QPTR_BITS-1:0] r_rd;
    logic [QPTR_BITS:0]   r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_stat.full  = (r_count == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push.valid && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/bdme_back.sv]
// ============================================================================
// bdme_back
// Serializes queued bundles into records and accumulates the cost.
// ============================================================================
module bdme_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bdme_pkg::t_bundle                i_head,
    input  bdme_pkg::t_q_stat                i_q_stat,
    output logic                             o_pop,
    input  logic [7:0]                       i_header_bytes,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [1:0]                       o_record_kind,
    output logic [31:0]                      o_position,
    output logic [31:0]                      o_run_length,
    output logic [bdme_pkg::COST_BITS-1:0]   o_total_cost,
    output logic                             o_last_record
);
    import bdme_pkg::*;

    logic [2:0]           r_done;
    logic [2:0]           n_done;
    logic                 r_valid;
    logic [COST_BITS-1:0] r_acc;
    t_kind                r_kind;
    logic [31:0]          r_pos;
    logic [31:0]          r_len;
    logic [COST_BITS-1:0] r_cost;
    logic                 r_last;

    logic                 load;
    logic                 pend_upd;
    logic                 pend_sur;
    logic                 pend_end;
    logic                 remaining;
    logic [2:0]           done_bit;
    t_kind                sel_kind;
    t_pos                 sel_pos;
    t_pos                 sel_len;
    logic [SUM_BITS-1:0]  sum;
    logic [COST_BITS-1:0] new_cost;

    assign load     = !i_q_stat.empty && (!r_valid || i_ready);
    assign pend_upd = i_head.upd.valid && !r_done[0];
    assign pend_sur = i_head.sur.valid && !r_done[1];
    assign pend_end = i_head.eos && !r_done[2];

    // Pick the first record of the head bundle that is still owed.
    always_comb begin
        if (pend_upd) begin
            sel_kind  = KIND_UPDATE;
            sel_pos   = i_head.upd.pos;
            sel_len   = i_head.upd.len;
            done_bit  = 3'b001;
            remaining = pend_sur || pend_end;
        end else if (pend_sur) begin
            sel_kind  = i_head.sur_kind;
            sel_pos   = i_head.sur.pos;
            sel_len   = i_head.sur.len;
            done_bit  = 3'b010;
            remaining = pend_end;
        end else begin
            sel_kind  = KIND_END;
            sel_pos   = '0;
            sel_len   = '0;
            done_bit  = 3'b100;
            remaining = 1'b0;
        end
    end

    always_comb begin
        sum = SUM_BITS'(r_acc) + SUM_BITS'(sel_len) + SUM_BITS'(i_header_bytes);
        if (sel_kind == KIND_END) begin
            new_cost = r_acc;
        end else if (sum > SUM_BITS'(COST_MAX)) begin
            new_cost = COST_MAX;
        end else begin
            new_cost = sum[COST_BITS-1:0];
        end
    end

    assign o_pop  = load && !remaining;
    assign n_done = o_pop ? 3'b000 : (r_done | done_bit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
            r_acc   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_done  <= n_done;
            r_acc   <= (sel_kind == KIND_END) ? '0 : new_cost;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= sel_kind;
            r_pos  <= to_out32(sel_pos);
            r_len  <= to_out32(sel_len);
            r_cost <= new_cost;
            r_last <= (sel_kind == KIND_END);
        end
    end

    assign o_valid       = r_valid;
    assign o_record_kind = r_kind;
    assign o_position    = r_pos;
    assign o_run_length  = r_len;
    assign o_total_cost  = r_cost;
    assign o_last_record = r_last;

endmodule

[sv/block_delta_mutation_encoder_top.sv]
// ============================================================================
// block_delta_mutation_encoder_top
// Fixed-block delta encoder: byte pairs in, mutation records and cost out.
// ============================================================================
//
//  Channel  | Handshake                  | Beat carries
//  ---------+----------------------------+------------------------------------
//  input    | i_valid / o_ready          | old/new byte, present flags, last
//  output   | o_valid / i_ready          | kind, position, length, cost, last
//  config   | i_cfg_valid / o_cfg_ready  | register index, write data
//
//  Cycles: one input beat per cycle while o_ready is high; each beat is
//  classified in the cycle it is accepted. Records leave one per cycle from
//  the output register while i_ready is high; a final beat can carry update,
//  surplus and end records. The queue holds four beats' worth of records.
//  Reset: synchronous; no clearing pass. Config resets to a block
//  size of 64 and a header size of 17; o_cfg_ready is always high.
//  Stalls: a low i_ready holds the output record; the queue fills behind it,
//  and o_ready drops only while the queue is full.
//
module block_delta_mutation_encoder_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [7:0]                           i_old_byte,
    input  logic [7:0]                           i_new_byte,
    input  logic                                 i_old_present,
    input  logic                                 i_new_present,
    input  logic                                 i_last_item,
    // output channel
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [1:0]                           o_record_kind,
    output logic [31:0]                          o_position,
    output logic [31:0]                          o_run_length,
    output logic [bdme_pkg::COST_BITS-1:0]       o_total_cost,
    output logic                                 o_last_record,
    // configuration channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bdme_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [bdme_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import bdme_pkg::*;

    logic [15:0] r_block_size;
    logic [7:0]  r_header_bytes;
    t_push       push;
    t_bundle     head;
    t_q_stat     q_stat;
    logic        pop;

    // Config writes always land; user alone keeps block idle as they arrive.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size   <= BLOCK_SIZE_RESET;
            r_header_bytes <= HEADER_BYTES_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_BLOCK_SIZE:   r_block_size   <= i_cfg_data[15:0];
                CFG_HEADER_BYTES: r_header_bytes <= i_cfg_data[7:0];
                default:          r_block_size   <= r_block_size;
            endcase
        end
    end

    // Front: classify each beat and build its record bundle.
    bdme_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_old_byte    (i_old_byte),
        .i_new_byte    (i_new_byte),
        .i_old_present (i_old_present),
        .i_new_present (i_new_present),
        .i_last_item   (i_last_item),
        .i_block_size  (r_block_size),
        .i_q_stat      (q_stat),
        .o_push        (push)
    );

    // Queue: decouple classification from record delivery.
    bdme_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // Back: drain bundles record by record and add up the cost.
    bdme_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .i_header_bytes (r_header_bytes),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_record_kind  (o_record_kind),
        .o_position     (o_position),
        .o_run_length   (o_run_length),
        .o_total_cost   (o_total_cost),
        .o_last_record  (o_last_record)
    );

endmodule

[sv/bdme_checker.sv]
// ============================================================================
// bdme_checker
// Port-level assertions for the delta mutation encoder, bound to the top.
// ============================================================================
`include "block_delta_mutation_encoder_top_assert.svh"

module bdme_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_ready,
    input logic [7:0]                           i_old_byte,
    input logic [7:0]                           i_new_byte,
    input logic                                 i_old_present,
    input logic                                 i_new_present,
    input logic                                 i_last_item,
    input logic                                 o_valid,
    input logic                                 i_ready,
    input logic [1:0]                           o_record_kind,
    input logic [31:0]                          o_position,
    input logic [31:0]                          o_run_length,
    input logic [bdme_pkg::COST_BITS-1:0]       o_total_cost,
    input logic                                 o_last_record,
    input logic                                 i_cfg_valid,
    input logic                                 o_cfg_ready,
    input logic [bdme_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input logic [bdme_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import bdme_pkg::*;

    // Hold a stalled output beat.
    `BDME_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_record_kind) && $stable(o_position) && $stable(o_run_length) && $stable(o_total_cost) && $stable(o_last_record), "stalled output beat changed")

    // The last-record flag marks exactly the end records.
    `BDME_ASSERT_IMP(a_end_flag, i_clk, i_rst_n, o_valid, (o_record_kind == KIND_END) == o_last_record, "end flag and record kind disagree")

    // End records carry no position or length.
    `BDME_ASSERT_IMP(a_end_empty, i_clk, i_rst_n, o_valid && o_last_record, (o_position == '0) && (o_run_length == '0), "end record with position or length")

    // Drop any output beat on reset.
    `BDME_ASSERT_NXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_valid, "output valid after reset")

endmodule

bind block_delta_mutation_encoder_top bdme_checker u_bdme_checker (.*);

[test/block_delta_mutation_encoder_top_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// block_delta_mutation_encoder_top_test
// Self-checking bench for the fixed-block delta encoder. A short table of
// directed beats and register writes runs first, then random runs of byte
// pairs with random block and header sizes. Every record is checked field by
// field against an in-bench model of the encoder.
// ============================================================================
module block_delta_mutation_encoder_top_test;

    import bdme_pkg::*;

    localparam int RANDOM_ITEMS   = 100;
    localparam int QUIET_AFTER    = 75;
    localparam int PRESSURE_AT    = 40;
    localparam int PRESSURE_BEATS = 12;
    localparam int LONG_HOLD      = 80;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 100;
    localparam int TIMEOUT_NS     = 2_000_000;

    // One expected output beat.
    typedef struct packed {
        t_kind                kind;
        logic [31:0]          pos;
        logic [31:0]          run_len;
        logic [COST_BITS-1:0] cost;
        logic                 is_end;
    } t_exp_rec;

    // One row of the directed table: a register write or an input beat.
    typedef struct {
        bit                   is_reg;
        t_cfg_index           reg_idx;
        logic [15:0]          reg_data;
        logic [7:0]           old_b;
        logic [7:0]           new_b;
        logic                 old_p;
        logic                 new_p;
        logic                 is_last;
        bit                   typed;
        logic [COST_BITS-1:0] typed_cost;
    } t_stim_row;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                      i_clk;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic                      o_ready;
    logic [7:0]                i_old_byte    = '0;
    logic [7:0]                i_new_byte    = '0;
    logic                      i_old_present = 1'b0;
    logic                      i_new_present = 1'b0;
    logic                      i_last_item   = 1'b0;
    logic                      o_valid;
    logic                      i_ready       = 1'b0;
    logic [1:0]                o_record_kind;
    logic [31:0]               o_position;
    logic [31:0]               o_run_length;
    logic [COST_BITS-1:0]      o_total_cost;
    logic                      o_last_record;
    logic                      i_cfg_valid   = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data    = '0;

    block_delta_mutation_encoder_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_old_byte    (i_old_byte),
        .i_new_byte    (i_new_byte),
        .i_old_present (i_old_present),
        .i_new_present (i_new_present),
        .i_last_item   (i_last_item),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_record_kind (o_record_kind),
        .o_position    (o_position),
        .o_run_length  (o_run_length),
        .o_total_cost  (o_total_cost),
        .o_last_record (o_last_record),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 10 ns period
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // Encoder model: registers and per-run state
    // ------------------------------------------------------------------------
    logic [15:0]          blk_size  = BLOCK_SIZE_RESET;
    logic [7:0]           hdr_bytes = HEADER_BYTES_RESET;
    t_pos                 overlap_pos;
    logic [15:0]          fill_cnt;
    logic                 blk_dirty;
    t_pos                 dirty_run;
    logic                 last_blk_dirty;
    t_pos                 old_seen;
    t_pos                 new_seen;
    logic                 in_overlap;
    logic [COST_BITS-1:0] cost_acc;

    t_exp_rec beat_records[$];     // records caused by the beat just accepted
    t_exp_rec pending_records[$];  // records still owed by the DUT

    int  items_sent       = 0;
    int  records_expected = 0;
    int  records_checked  = 0;
    int  reg_writes       = 0;
    int  err_count        = 0;
    bit  quiet            = 1'b0;  // no idling on either side
    bit  burst_mode       = 1'b0;  // sender offers back to back
    bit  long_hold_req    = 1'b0;

    task automatic restart_run();
        overlap_pos    = '0;
        fill_cnt       = '0;
        blk_dirty      = 1'b0;
        dirty_run      = '0;
        last_blk_dirty = 1'b0;
        old_seen       = '0;
        new_seen       = '0;
        in_overlap     = 1'b1;
        cost_acc       = '0;
    endtask

    task automatic post_record(t_kind kind, t_pos start, t_pos length, logic is_end);
        logic [COST_BITS:0] sum;
        t_exp_rec           rec;
        // The end record reports the total without adding to it.
        if (kind != KIND_END) begin
            sum = {1'b0, cost_acc} + (COST_BITS+1)'(length) + (COST_BITS+1)'(hdr_bytes);
            cost_acc = sum[COST_BITS] ? COST_MAX : sum[COST_BITS-1:0];
        end
        rec.kind    = kind;
        rec.pos     = 32'(start);
        rec.run_len = 32'(length);
        rec.cost    = cost_acc;
        rec.is_end  = is_end;
        beat_records.insert(beat_records.size(), rec);
    endtask

    // Close the block of size bytes that ends at overlap_pos.
    task automatic seal_block(logic [16:0] size);
        if (blk_dirty) begin
            dirty_run      = dirty_run + t_pos'(size);
            last_blk_dirty = 1'b1;
        end else if (last_blk_dirty) begin
            post_record(KIND_UPDATE, overlap_pos - t_pos'(size) - dirty_run, dirty_run, 1'b0);
            dirty_run      = '0;
            last_blk_dirty = 1'b0;
        end
        fill_cnt  = '0;
        blk_dirty = 1'b0;
    endtask

    // Close a partial block at its true size, then flush any open run.
    task automatic end_overlap();
        if (fill_cnt != 16'd0)
            seal_block({1'b0, fill_cnt});
        if (last_blk_dirty) begin
            post_record(KIND_UPDATE, overlap_pos - dirty_run, dirty_run, 1'b0);
            dirty_run      = '0;
            last_blk_dirty = 1'b0;
        end
    endtask

    task automatic predict_beat(logic [7:0] ob, logic [7:0] nb, logic op, logic np,
                                logic is_last);
        logic [16:0] filled;
        logic [16:0] target;
        if (in_overlap && op && np) begin
            filled      = {1'b0, fill_cnt} + 17'd1;
            target      = (blk_size == 16'd0) ? FULL_BLOCK : {1'b0, blk_size};
            overlap_pos = overlap_pos + 1'b1;
            if (ob != nb)
                blk_dirty = 1'b1;
            if (filled >= target)
                seal_block(filled);
            else
                fill_cnt = filled[15:0];
        end else if (in_overlap && (op || np)) begin
            end_overlap();
            in_overlap = 1'b0;
        end
        if (op)
            old_seen = old_seen + 1'b1;
        if (np)
            new_seen = new_seen + 1'b1;
        if (is_last) begin
            if (in_overlap)
                end_overlap();
            if (old_seen > new_seen)
                post_record(KIND_DELETE, new_seen, old_seen - new_seen, 1'b0);
            else if (new_seen > old_seen)
                post_record(KIND_INSERT, old_seen, new_seen - old_seen, 1'b0);
            post_record(KIND_END, '0, '0, 1'b1);
            restart_run();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender side. Tasks start and end on a falling edge.
    // ------------------------------------------------------------------------
    task automatic push_item(logic [7:0] ob, logic [7:0] nb, logic op, logic np,
                             logic is_last, bit typed, logic [COST_BITS-1:0] typed_cost);
        t_exp_rec end_rec;
        // Raise valid with the payload and hold it until the beat is taken.
        i_valid       = 1'b1;
        i_old_byte    = ob;
        i_new_byte    = nb;
        i_old_present = op;
        i_new_present = np;
        i_last_item   = is_last;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        beat_records.delete();
        predict_beat(ob, nb, op, np, is_last);
        if (typed) begin
            // Typed-in rows carry a single end record known at a glance.
            end_rec = '{kind: KIND_END, pos: '0, run_len: '0, cost: typed_cost, is_end: 1'b1};
            pending_records.insert(pending_records.size(), end_rec);
            records_expected++;
        end else begin
            foreach (beat_records[k])
                pending_records.insert(pending_records.size(), beat_records[k]);
            records_expected += beat_records.size();
        end
        items_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
        // Drop valid for a random burst now and then.
        if (!quiet && !burst_mode && $urandom_range(0, 99) < 25)
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
    endtask

    // Write a register only once the DUT has nothing left in flight.
    task automatic write_reg(t_cfg_index idx, logic [15:0] data);
        while (pending_records.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx == CFG_BLOCK_SIZE)
            blk_size = data;
        else
            hdr_bytes = data[7:0];
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // One run: an overlap with a random mismatch rate, some noise, a surplus
    // on one side, and a closing beat with the last flag.
    task automatic run_random();
        int         ov_len;
        int         sur_len;
        int         miss_pct;
        int         k;
        bit         old_side;
        logic [7:0] a;
        logic [7:0] b;
        ov_len   = $urandom_range(0, 12);
        sur_len  = $urandom_range(0, 5);
        miss_pct = $urandom_range(0, 60);
        old_side = 1'($urandom_range(0, 1));
        for (k = 0; k < ov_len; k++) begin
            a = 8'($urandom_range(0, 255));
            b = ($urandom_range(0, 99) < miss_pct) ? 8'($urandom_range(0, 255)) : a;
            if ($urandom_range(0, 99) < 10)
                push_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'b0, 1'b0, '0);
            else
                push_item(a, b, 1'b1, 1'b1, 1'b0, 1'b0, '0);
        end
        for (k = 0; k < sur_len; k++) begin
            a = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
            // Now and then both sides show a byte past the overlap.
            if ($urandom_range(0, 99) < 10)
                push_item(a, b, 1'b1, 1'b1, 1'b0, 1'b0, '0);
            else
                push_item(a, b, old_side, !old_side, 1'b0, 1'b0, '0);
        end
        a = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 2))
            0: begin
                push_item(a, b, old_side, !old_side, 1'b1, 1'b0, '0);
            end
            1: begin
                push_item(a, b, 1'b1, 1'b1, 1'b1, 1'b0, '0);
            end
            default: begin
                push_item(a, b, 1'b0, 1'b0, 1'b1, 1'b0, '0);
            end
        endcase
    endtask

    function automatic t_stim_row item_row(logic [7:0] ob, logic [7:0] nb, logic op,
                                           logic np, logic is_last);
        t_stim_row row;
        row          = '{default: '0, reg_idx: CFG_BLOCK_SIZE};
        row.old_b    = ob;
        row.new_b    = nb;
        row.old_p    = op;
        row.new_p    = np;
        row.is_last  = is_last;
        return row;
    endfunction

    // Nothing present with the last flag on a fresh run: an end record of the
    // given cost and nothing else.
    function automatic t_stim_row end_row(logic [COST_BITS-1:0] cost);
        t_stim_row row;
        row            = '{default: '0, reg_idx: CFG_BLOCK_SIZE};
        row.is_last    = 1'b1;
        row.typed      = 1'b1;
        row.typed_cost = cost;
        return row;
    endfunction

    function automatic t_stim_row reg_row(t_cfg_index idx, logic [15:0] data);
        t_stim_row row;
        row          = '{default: '0, reg_idx: CFG_BLOCK_SIZE};
        row.is_reg   = 1'b1;
        row.reg_idx  = idx;
        row.reg_data = data;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side: random ready bursts, plus one long counted hold-off.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int hold_left;
        int idle_left;
        hold_left = 0;
        idle_left = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready = 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                i_ready = 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < 15) begin
                idle_left = $urandom_range(1, 5) - 1;
                i_ready   = 1'b0;
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    task automatic check_field(string name, logic [COST_BITS-1:0] want,
                               logic [COST_BITS-1:0] got);
        if (want !== got) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Check each output beat against the oldest outstanding record.
    always @(posedge i_clk) begin
        t_exp_rec want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_records.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected record, expected none, actual kind %0d pos %0d len %0d cost %0d",
                             $time, o_record_kind, o_position, o_run_length, o_total_cost);
            end else begin
                want = pending_records.pop_front();
                check_field("record_kind", COST_BITS'(want.kind), COST_BITS'(o_record_kind));
                check_field("position", COST_BITS'(want.pos), COST_BITS'(o_position));
                check_field("run_length", COST_BITS'(want.run_len), COST_BITS'(o_run_length));
                check_field("total_cost", want.cost, o_total_cost);
                check_field("last_record", COST_BITS'(want.is_end), COST_BITS'(o_last_record));
                records_checked++;
            end
        end
    end

    // Hard stop in case the DUT hangs.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_stim_row   dir_table[$];
        int          rand_base;
        int          runs;
        int          pick;
        int          k;
        bit          pressure_done;
        logic [15:0] bs;

        restart_run();
        pressure_done = 1'b0;

        // Hold reset low, then release it on a falling edge.
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset values: block size 64, header 17.
        dir_table.insert(dir_table.size(), end_row(40'd0));
        dir_table.insert(dir_table.size(), item_row(8'h00, 8'hFF, 1'b1, 1'b1, 1'b0));
        dir_table.insert(dir_table.size(), item_row(8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0));
        // Old runs out: partial dirty block, update, delete, end.
        dir_table.insert(dir_table.size(), item_row(8'h5A, 8'h00, 1'b1, 1'b0, 1'b1));
        dir_table.insert(dir_table.size(), item_row(8'h00, 8'hC3, 1'b0, 1'b1, 1'b1));
        // Bytes past the overlap are only counted; an empty beat changes nothing.
        dir_table.insert(dir_table.size(), item_row(8'hA5, 8'hA5, 1'b1, 1'b1, 1'b0));
        dir_table.insert(dir_table.size(), item_row(8'h00, 8'hC3, 1'b0, 1'b1, 1'b0));
        dir_table.insert(dir_table.size(), item_row(8'h00, 8'h00, 1'b1, 1'b1, 1'b0));
        dir_table.insert(dir_table.size(), item_row(8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0));
        dir_table.insert(dir_table.size(), item_row(8'h00, 8'hFF, 1'b0, 1'b1, 1'b1));
        // Smallest block, free headers; upper data bits must be ignored.
        dir_table.insert(dir_table.size(), reg_row(CFG_BLOCK_SIZE, 16'd1));
        dir_table.insert(dir_table.size(), reg_row(CFG_HEADER_BYTES, 16'hFF00));
        dir_table.insert(dir_table.size(), item_row(8'h12, 8'h34, 1'b1, 1'b1, 1'b0));
        dir_table.insert(dir_table.size(), item_row(8'h55, 8'h55, 1'b1, 1'b1, 1'b0));
        dir_table.insert(dir_table.size(), item_row(8'hAA, 8'hBB, 1'b1, 1'b1, 1'b0));
        dir_table.insert(dir_table.size(), item_row(8'h01, 8'h01, 1'b1, 1'b1, 1'b1));
        dir_table.insert(dir_table.size(), end_row(40'd0));
        // Largest block and header.
        dir_table.insert(dir_table.size(), reg_row(CFG_BLOCK_SIZE, 16'hFFFF));
        dir_table.insert(dir_table.size(), reg_row(CFG_HEADER_BYTES, 16'h00FF));
        dir_table.insert(dir_table.size(), item_row(8'h80, 8'h7F, 1'b1, 1'b1, 1'b0));
        dir_table.insert(dir_table.size(), item_row(8'h7F, 8'h7F, 1'b1, 1'b1, 1'b0));
        dir_table.insert(dir_table.size(), item_row(8'h01, 8'h00, 1'b1, 1'b0, 1'b1));
        // Block size zero stands for a 64 KiB block.
        dir_table.insert(dir_table.size(), reg_row(CFG_BLOCK_SIZE, 16'd0));
        dir_table.insert(dir_table.size(), item_row(8'hFF, 8'h00, 1'b1, 1'b1, 1'b0));
        dir_table.insert(dir_table.size(), item_row(8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1));
        // Three-byte blocks: dirty block, then a clean one closes the run.
        dir_table.insert(dir_table.size(), reg_row(CFG_BLOCK_SIZE, 16'd3));
        dir_table.insert(dir_table.size(), reg_row(CFG_HEADER_BYTES, 16'd17));
        dir_table.insert(dir_table.size(), item_row(8'h01, 8'h00, 1'b1, 1'b1, 1'b0));
        dir_table.insert(dir_table.size(), item_row(8'h02, 8'h02, 1'b1, 1'b1, 1'b0));
        dir_table.insert(dir_table.size(), item_row(8'h03, 8'h03, 1'b1, 1'b1, 1'b0));
        dir_table.insert(dir_table.size(), item_row(8'h04, 8'h04, 1'b1, 1'b1, 1'b0));
        dir_table.insert(dir_table.size(), item_row(8'h05, 8'h05, 1'b1, 1'b1, 1'b0));
        dir_table.insert(dir_table.size(), item_row(8'h06, 8'h06, 1'b1, 1'b1, 1'b0));
        dir_table.insert(dir_table.size(), item_row(8'h07, 8'h00, 1'b1, 1'b0, 1'b1));

        foreach (dir_table[k]) begin
            if (dir_table[k].is_reg)
                write_reg(dir_table[k].reg_idx, dir_table[k].reg_data);
            else
                push_item(dir_table[k].old_b, dir_table[k].new_b, dir_table[k].old_p,
                          dir_table[k].new_p, dir_table[k].is_last, dir_table[k].typed,
                          dir_table[k].typed_cost);
        end

        // Random phases: new register values, then one or two runs.
        rand_base = items_sent;
        while (items_sent - rand_base < RANDOM_ITEMS) begin
            // Mostly small blocks, so that blocks close often.
            pick = $urandom_range(0, 99);
            if (pick < 70)
                bs = 16'($urandom_range(1, 8));
            else if (pick < 90)
                bs = 16'($urandom_range(9, 70));
            else if (pick < 95)
                bs = 16'hFFFF;
            else
                bs = 16'($urandom_range(0, 65535));
            write_reg(CFG_BLOCK_SIZE, bs);
            write_reg(CFG_HEADER_BYTES, 16'($urandom_range(0, 65535)));

            if (!pressure_done && items_sent - rand_base >= PRESSURE_AT) begin
                // Stall the receiver while short runs arrive back to back,
                // so the record queue fills and the input stalls.
                pressure_done = 1'b1;
                long_hold_req = 1'b1;
                burst_mode    = 1'b1;
                for (k = 0; k < PRESSURE_BEATS; k++)
                    push_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'b1, 1'b0, '0);
                burst_mode = 1'b0;
            end

            quiet = (items_sent - rand_base >= QUIET_AFTER);
            runs  = $urandom_range(1, 2);
            for (k = 0; k < runs; k++)
                run_random();
        end

        // Drain, then keep clocking so that stray beats can show.
        while (pending_records.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input beats in runs of mixed shape, %0d register writes",
                 items_sent, reg_writes);
        $display("checked %0d of %0d expected output records, %0d field errors",
                 records_checked, records_expected, err_count);
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[block_delta_mutation_encoder_top.f]
+incdir+sv
sv/bdme_pkg.sv
sv/bdme_front.sv
sv/bdme_queue.sv
sv/bdme_back.sv
sv/block_delta_mutation_encoder_top.sv
sv/bdme_checker.sv
test/block_delta_mutation_encoder_top_test.sv
